@@ design/kpsd_pkg.sv @@
// shared types and constants for the keypad scan digit shift display unit
`timescale 1ns / 1ps
package kpsd_pkg;

	localparam int DIGITS       = 8;
	localparam int SHOWN_DIGITS = 8;
	localparam int ROWS         = 4;
	localparam int ROW_W        = $clog2(ROWS);
	localparam int DIGIT_W      = 5;
	localparam int KEY_W        = 4;
	localparam int COL_W        = 4;

	localparam logic [DIGIT_W-1:0] BLANK_DIGIT = DIGIT_W'(16);

	// one-hot column codes, column 1 is the top bit
	localparam logic [COL_W-1:0] COL_ONE   = 4'b1000;
	localparam logic [COL_W-1:0] COL_TWO   = 4'b0100;
	localparam logic [COL_W-1:0] COL_THREE = 4'b0010;
	localparam logic [COL_W-1:0] COL_FOUR  = 4'b0001;

	typedef logic [DIGIT_W-1:0] digit_t;
	typedef logic [DIGITS-1:0][DIGIT_W-1:0] digit_vec_t;
	typedef logic [ROW_W-1:0] row_t;
	typedef logic [COL_W-1:0] cols_t;

	typedef struct packed {
		logic reverse;
		logic held;
		row_t row;
	} ctrl_t;

endpackage

@@ design/kpsd_step.sv @@
// next-state logic for one poll tick: switch toggle, key decode and digit shift
`timescale 1ns / 1ps
module kpsd_step (
	input  kpsd_pkg::ctrl_t     ctrl,
	input  kpsd_pkg::digit_vec_t digits,
	input  logic                switch_down,
	input  kpsd_pkg::cols_t     column_sense,
	output kpsd_pkg::ctrl_t     ctrl_next,
	output kpsd_pkg::digit_vec_t digits_next,
	output logic                changed
);
	import kpsd_pkg::*;

	logic             key_hit;
	logic [KEY_W-1:0] key_col;
	logic [KEY_W-1:0] key;

	// column position within the row, zero-based
	always_comb begin
		key_hit = 1'b1;
		key_col = '0;
		unique case (column_sense)
			COL_ONE:   key_col = KEY_W'(0);
			COL_TWO:   key_col = KEY_W'(1);
			COL_THREE: key_col = KEY_W'(2);
			COL_FOUR:  key_col = KEY_W'(3);
			default:   key_hit = 1'b0;
		endcase
	end

	// row*4 + col + 1, with the last key wrapping to 0 in four bits
	assign key = KEY_W'({ctrl.row, 2'b00}) + key_col + KEY_W'(1);

	always_comb begin
		ctrl_next   = ctrl;
		digits_next = digits;
		changed     = 1'b0;

		if (!ctrl.held && switch_down) begin
			ctrl_next.reverse = ~ctrl.reverse;
			ctrl_next.held    = 1'b1;
			changed           = 1'b1;
			for (int i = 0; i < DIGITS; i++) begin
				digits_next[i] = BLANK_DIGIT;
			end
		end

		if (!ctrl_next.held) begin
			ctrl_next.row = ctrl.row + row_t'(1);
			if (key_hit) begin
				changed        = 1'b1;
				ctrl_next.held = 1'b1;
				if (!ctrl.reverse) begin
					for (int i = 1; i < DIGITS; i++) begin
						digits_next[i] = digits[i-1];
					end
					digits_next[0] = {1'b0, key};
				end else begin
					for (int i = 0; i < DIGITS - 1; i++) begin
						digits_next[i] = digits[i+1];
					end
					digits_next[DIGITS-1] = {1'b0, key};
				end
			end
		end

		// release seen on the same tick's inputs
		if (ctrl_next.held && !switch_down && column_sense == '0) begin
			ctrl_next.held = 1'b0;
		end
	end

endmodule

@@ design/keypad_scan_digit_shift_display_unit.sv @@
// keypad scanner with shifting hex-digit display, top level
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_ready  | switch_down, column_sense
//  out     | out_valid / out_ready| sense_row, display_changed, reversed, digits
//
// an accepted tick is registered, then evaluated against the scan state and
// placed in the result register; one tick per cycle is sustained while the
// output is not stalled. reset blanks all digits, clears direction and hold and
// points the scan at row 0. a stall on the output holds the result register and
// a full input register, and input is taken again as soon as the result moves
`timescale 1ns / 1ps
module keypad_scan_digit_shift_display_unit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   switch_down,
	input  logic [3:0]             column_sense,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [1:0]             sense_row,
	output logic                   display_changed,
	output logic                   reversed,
	output logic [4:0]             digit_zero,
	output logic [4:0]             digit_one,
	output logic [4:0]             digit_two,
	output logic [4:0]             digit_three,
	output logic [4:0]             digit_four,
	output logic [4:0]             digit_five,
	output logic [4:0]             digit_six,
	output logic [4:0]             digit_seven
);
	import kpsd_pkg::*;

	// input register
	logic  valid_s1;
	logic  switch_s1;
	cols_t cols_s1;

	// scan state
	ctrl_t      ctrl_q;
	digit_vec_t digits_q;

	ctrl_t      ctrl_next;
	digit_vec_t digits_next;
	logic       changed;

	// result register
	logic       out_valid_q;
	row_t       out_row_q;
	logic       out_changed_q;
	logic       out_rev_q;
	digit_vec_t out_digits_q;

	logic [SHOWN_DIGITS-1:0][DIGIT_W-1:0] shown;

	logic advance;

	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;

	kpsd_step u_step (
		.ctrl         (ctrl_q),
		.digits       (digits_q),
		.switch_down  (switch_s1),
		.column_sense (cols_s1),
		.ctrl_next    (ctrl_next),
		.digits_next  (digits_next),
		.changed      (changed)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			switch_s1 <= switch_down;
			cols_s1   <= column_sense;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < DIGITS; i++) begin
				digits_q[i] <= BLANK_DIGIT;
			end
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				ctrl_q   <= ctrl_next;
				digits_q <= digits_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_row_q     <= ctrl_next.row;
			out_changed_q <= changed;
			out_rev_q     <= ctrl_next.reverse;
			out_digits_q  <= digits_next;
		end
	end

	// digits beyond the stored count read as blank
	for (genvar g = 0; g < SHOWN_DIGITS; g++) begin : g_shown
		if (g < DIGITS) begin : g_kept
			assign shown[g] = out_digits_q[g];
		end else begin : g_blank
			assign shown[g] = BLANK_DIGIT;
		end
	end

	assign out_valid       = out_valid_q;
	assign sense_row       = out_row_q;
	assign display_changed = out_changed_q;
	assign reversed        = out_rev_q;
	assign digit_zero      = shown[0];
	assign digit_one       = shown[1];
	assign digit_two       = shown[2];
	assign digit_three     = shown[3];
	assign digit_four      = shown[4];
	assign digit_five      = shown[5];
	assign digit_six       = shown[6];
	assign digit_seven     = shown[7];

endmodule
